>>> design/q2_q8_block_scaled_dot_core_defines.svh
// Assertion macros shared by the checker.
`ifndef Q2_Q8_BLOCK_SCALED_DOT_CORE_DEFINES_SVH
`define Q2_Q8_BLOCK_SCALED_DOT_CORE_DEFINES_SVH

// Next-cycle implication, muted while reset is asserted.
`define QDC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define QDC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/qdc_pkg.sv
`default_nettype none
package qdc_pkg;

    localparam int TDATA_IN_W  = 72;
    localparam int TDATA_OUT_W = 32;
    localparam int DEF_SUBBLOCK_LEN = 32;
    // widest partial sum over the largest sub-block
    localparam int PART_W = 18;

    typedef struct packed {
        logic [15:0]        weight_scale;
        logic [15:0]        act_scale;
        logic [PART_W-1:0]  partial;
        logic               last;
    } qdc_flush_t;

endpackage
`default_nettype wire

>>> design/q2_q8_block_scaled_dot_core.sv
// Block-scaled dot product of 2-bit weights against signed 8-bit activations.
// Input stream s_*: one transfer carries a group of four elements; s_tlast marks
// the final group of a row. Output stream m_*: one fp32 result per row.
// The front end takes one transfer per cycle while the queue is not full, sums
// the four integer products and accumulates them; every SUBBLOCK_LEN/4 groups,
// or on s_tlast, it pushes the partial sum and the scales of that transfer into
// a 2-entry queue. The back end drains the queue one entry at a time through
// decode, scale product, scaled partial and accumulate (round to nearest even,
// subnormals kept). Sustained rate is one transfer per cycle as long as a
// sub-block holds at least four groups and the receiver does not stall; shorter
// sub-blocks are bounded by the float sequence.
// From an empty queue and idle back end, the s_tlast entry passes the queue, then
// decode, both products and accumulate, and the output register raises m_tvalid.
// Reset clears the partial sum, group count, accumulator and m_tvalid.
// A stalled receiver holds the result in the output register; the queue then
// fills and s_tready drops until m_tready returns.
`default_nettype none
module q2_q8_block_scaled_dot_core #(
    parameter int SUBBLOCK_LEN = qdc_pkg::DEF_SUBBLOCK_LEN
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // weight_codes, act_0, act_1, act_2, act_3, weight_scale, act_scale
    input  wire logic [qdc_pkg::TDATA_IN_W-1:0]    s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // dot_result
    output logic [qdc_pkg::TDATA_OUT_W-1:0]        m_tdata
);
    import qdc_pkg::*;

    qdc_flush_t push_data, pop_data;
    logic       q_push, q_pop, q_full, q_valid;

    qdc_front #(
        .SUBBLOCK_LEN (SUBBLOCK_LEN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    qdc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_data),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (pop_data),
        .valid   (q_valid)
    );

    qdc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire

>>> design/qdc_front.sv
`default_nettype none
module qdc_front #(
    parameter int SUBBLOCK_LEN = qdc_pkg::DEF_SUBBLOCK_LEN
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [qdc_pkg::TDATA_IN_W-1:0] in_data,
    input  wire logic                          in_last,
    input  wire logic                          q_full,
    output logic                               q_push,
    output qdc_pkg::qdc_flush_t                q_data
);
    import qdc_pkg::*;

    localparam int PER_SUB = (SUBBLOCK_LEN / 4 < 1) ? 1 : SUBBLOCK_LEN / 4;
    localparam int CNT_W   = (PER_SUB < 2) ? 1 : $clog2(PER_SUB);
    localparam int LOC_W   = $clog2(PER_SUB * 1024) + 2;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [LOC_W-1:0] partial_reg, partial_next, partial_sum;
    logic signed [12:0]      group_sum;
    logic                    accept, flush;

    always_comb begin
        logic signed [2:0]  w;
        logic signed [7:0]  a;
        group_sum = '0;
        for (int i = 0; i < 4; i++) begin
            w = $signed({1'b0, in_data[2*i +: 2]}) - 3'sd1;
            a = $signed(in_data[8 + 8*i +: 8]);
            group_sum = group_sum + 13'(w) * 13'(a);
        end
    end

    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;
    assign partial_sum = partial_reg + LOC_W'(group_sum);
    assign flush       = in_last || (count_reg == CNT_W'(PER_SUB - 1));
    assign q_push      = accept && flush;

    always_comb begin
        q_data.weight_scale = in_data[40 +: 16];
        q_data.act_scale    = in_data[56 +: 16];
        q_data.partial      = PART_W'(partial_sum);
        q_data.last         = in_last;
        count_next   = count_reg;
        partial_next = partial_reg;
        if (accept) begin
            if (flush) begin
                count_next   = '0;
                partial_next = '0;
            end else begin
                count_next   = count_reg + CNT_W'(1);
                partial_next = partial_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            partial_reg <= '0;
        end else begin
            count_reg   <= count_next;
            partial_reg <= partial_next;
        end
    end

endmodule
`default_nettype wire

>>> design/qdc_fifo.sv
`default_nettype none
module qdc_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire qdc_pkg::qdc_flush_t din,
    output logic               full,
    input  wire logic          pop,
    output qdc_pkg::qdc_flush_t dout,
    output logic               valid
);
    import qdc_pkg::*;

    qdc_flush_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> design/qdc_back.sv
`default_nettype none
module qdc_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    input  wire qdc_pkg::qdc_flush_t            q_data,
    output logic                                q_pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [qdc_pkg::TDATA_OUT_W-1:0]     out_data
);
    import qdc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_ADD  = 2'd3;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] INF_MAG      = 32'h7F80_0000;

    function automatic logic [31:0] round_pack(input logic sign, input int exp,
                                               input logic [63:0] sig);
        int          msb;
        int          be;
        int          rsh;
        logic [63:0] n;
        logic [63:0] sh;
        logic [23:0] man;
        logic        g;
        logic        st;
        logic [30:0] mag;
        msb = 0;
        for (int i = 0; i < 64; i++) begin
            if (sig[i]) begin
                msb = i;
            end
        end
        n  = sig << (63 - msb);
        be = exp + msb + 127;
        if (sig == 64'd0) begin
            return {sign, 31'd0};
        end
        if (be >= 255) begin
            return {sign, INF_MAG[30:0]};
        end
        if (be >= 1) begin
            man = n[63:40];
            g   = n[39];
            st  = |n[38:0];
            mag = {be[7:0], man[22:0]};
        end else begin
            rsh = 1 - be;
            if (rsh > 40) begin
                man = '0;
                g   = 1'b0;
                st  = 1'b1;
            end else begin
                sh  = n >> rsh;
                man = sh[63:40];
                g   = sh[39];
                st  = (|sh[38:0]) | (|(n & ((64'd1 << rsh) - 64'd1)));
            end
            mag = {8'd0, man[22:0]};
        end
        if (g && (st || man[0])) begin
            mag = mag + 31'd1;
        end
        return {sign, mag};
    endfunction

    function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
        logic [4:0] e;
        e = h[14:10];
        if (e == 5'd0) begin
            return round_pack(h[15], -24, {54'd0, h[9:0]});
        end else if (e == 5'd31) begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        return {h[15], 8'(e) + 8'd112, h[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] int_to_fp32(input logic [PART_W-1:0] p);
        logic              neg;
        logic [PART_W-1:0] mag;
        neg = p[PART_W-1];
        mag = neg ? (~p + PART_W'(1)) : p;
        return round_pack(neg, 0, 64'(mag));
    endfunction

    function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [23:0] ma, mb;
        int          ea, eb;
        logic [47:0] p;
        s      = a[31] ^ b[31];
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb     = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        p      = 48'(ma) * 48'(mb);
        if (a_nan) begin
            return a | 32'h0040_0000;
        end else if (b_nan) begin
            return b | 32'h0040_0000;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            return QNAN_DEFAULT;
        end else if (a_inf || b_inf) begin
            return {s, INF_MAG[30:0]};
        end else if (a_zero || b_zero) begin
            return {s, 31'd0};
        end
        return round_pack(s, ea + eb - 300, {16'd0, p});
    endfunction

    function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan, b_nan, a_inf, b_inf;
        logic [31:0] x, y;
        logic [23:0] mx, my;
        int          ex, ey, d;
        logic [26:0] mx27, my27, my_al;
        logic [27:0] s;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        mx   = {x[30:23] != 8'd0, x[22:0]};
        my   = {y[30:23] != 8'd0, y[22:0]};
        ex   = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
        ey   = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
        d    = ex - ey;
        mx27 = {mx, 3'd0};
        my27 = {my, 3'd0};
        if (d >= 27) begin
            my_al = {26'd0, my27 != 27'd0};
        end else begin
            my_al = (my27 >> d) | {26'd0, |(my27 & ((27'd1 << d) - 27'd1))};
        end
        if (x[31] == y[31]) begin
            s = 28'(mx27) + 28'(my_al);
        end else begin
            s = 28'(mx27) - 28'(my_al);
        end
        if (a_nan) begin
            return a | 32'h0040_0000;
        end else if (b_nan) begin
            return b | 32'h0040_0000;
        end else if (a_inf && b_inf && (a[31] != b[31])) begin
            return QNAN_DEFAULT;
        end else if (a_inf) begin
            return a;
        end else if (b_inf) begin
            return b;
        end else if (s == 28'd0) begin
            return {a[31] & b[31], 31'd0};
        end
        return round_pack(x[31], ex - 153, {36'd0, s});
    endfunction

    logic [1:0]  state_reg, state_next;
    logic [31:0] ws_reg, ws_next, as_reg, as_next, pf_reg, pf_next;
    logic [31:0] sc_reg, sc_next, term_reg, term_next, acc_reg, acc_next;
    logic [31:0] out_reg, out_next;
    logic        last_reg, last_next, out_valid_reg, out_valid_next;
    logic [31:0] acc_sum;

    assign acc_sum   = fp32_add(acc_reg, term_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        as_next        = as_reg;
        pf_next        = pf_reg;
        sc_next        = sc_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        last_next      = last_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    ws_next    = fp16_to_fp32(q_data.weight_scale);
                    as_next    = fp16_to_fp32(q_data.act_scale);
                    pf_next    = int_to_fp32(q_data.partial);
                    last_next  = q_data.last;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                sc_next    = fp32_mul(as_reg, ws_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                term_next  = fp32_mul(sc_reg, pf_reg);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (!last_reg) begin
                    acc_next   = acc_sum;
                    state_next = ST_IDLE;
                end else if (!out_valid_reg || out_ready) begin
                    out_next       = acc_sum;
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ws_reg   <= ws_next;
        as_reg   <= as_next;
        pf_reg   <= pf_next;
        sc_reg   <= sc_next;
        term_reg <= term_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> design/qdc_checker.sv
`default_nettype none
`include "q2_q8_block_scaled_dot_core_defines.svh"
module qdc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    `QDC_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped")
    `QDC_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed")
    `QDC_ASSERT_NEXT_ALWAYS(a_rst_out, aclk, !aresetn, !m_tvalid, "result after reset")
    `QDC_ASSERT_NEXT_ALWAYS(a_rst_in, aclk, !aresetn, s_tready, "queue not empty after reset")
endmodule

bind q2_q8_block_scaled_dot_core qdc_checker u_qdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    typedef logic [319:0] wide_t;

    localparam int GROUPS_PER_SUB = (qdc_pkg::DEF_SUBBLOCK_LEN / 4 < 1) ?
                                    1 : qdc_pkg::DEF_SUBBLOCK_LEN / 4;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [qdc_pkg::TDATA_IN_W-1:0] s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [qdc_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic idle_on;
    int cycles;
    int stall_left;

    q2_q8_block_scaled_dot_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // fixed point in units of 2^-149, rounded to nearest even single
    function automatic logic [31:0] round_f32(input logic s, input wide_t m);
        int p;
        int sh;
        int ef;
        wide_t mant;
        logic g;
        logic st;
        p = -1;
        for (int i = 0; i < 320; i++) begin
            if (m[i]) p = i;
        end
        if (p < 0) return {s, 31'd0};
        if (p < 23) return {s, 8'd0, m[22:0]};
        sh = p - 23;
        mant = m >> sh;
        g = 1'b0;
        st = 1'b0;
        if (sh > 0) begin
            g = m[sh-1];
            st = (m & ((wide_t'(1) << (sh - 1)) - 1)) != 0;
        end
        if (g && (st || mant[0])) begin
            mant = mant + 1;
            if (mant[24]) begin
                mant = mant >> 1;
                p++;
            end
        end
        ef = p - 22;
        if (ef >= 255) return {s, 8'hFF, 23'd0};
        return {s, ef[7:0], mant[22:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return (&f[30:23]) && (|f[22:0]);
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return (&f[30:23]) && !(|f[22:0]);
    endfunction

    function automatic int exp_shift(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? 0 : int'(f[30:23]) - 1;
    endfunction

    function automatic wide_t mant_of(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? wide_t'(f[22:0]) : wide_t'({1'b1, f[22:0]});
    endfunction

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        int total;
        wide_t prod;
        s = a[31] ^ b[31];
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return DEFAULT_NAN;
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
        prod = mant_of(a) * mant_of(b);
        total = exp_shift(a) + exp_shift(b) - 149;
        if (total >= 0) prod = prod << total;
        else prod = prod >> (-total);
        return round_f32(s, prod);
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        wide_t ma;
        wide_t mb;
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return DEFAULT_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        ma = mant_of(a) << exp_shift(a);
        mb = mant_of(b) << exp_shift(b);
        if (a[31] == b[31]) return round_f32(a[31], ma + mb);
        if (ma > mb) return round_f32(a[31], ma - mb);
        if (mb > ma) return round_f32(b[31], mb - ma);
        return 32'd0;
    endfunction

    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        if (h[14:10] == 5'd0) return round_f32(h[15], wide_t'(h[9:0]) << 125);
        if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
        return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] int_to_f32(input int v);
        int mag;
        mag = (v < 0) ? -v : v;
        return round_f32(v < 0, wide_t'(mag) << 149);
    endfunction

    class dot_scoreboard;
        int partial_sum;
        int group_cnt;
        logic [31:0] acc = 32'd0;
        logic [31:0] expected_dots[$];
        int errors;

        function void note_group(input logic [71:0] d, input logic last);
            logic [31:0] scale;
            int w;
            for (int i = 0; i < 4; i++) begin
                w = int'(d[2*i +: 2]) - 1;
                partial_sum += w * int'($signed(d[8 + 8*i +: 8]));
            end
            group_cnt++;
            if (group_cnt >= GROUPS_PER_SUB || last) begin
                scale = f32_mul(half_to_f32(d[71:56]), half_to_f32(d[55:40]));
                acc = f32_add(acc, f32_mul(scale, int_to_f32(partial_sum)));
                partial_sum = 0;
                group_cnt = 0;
            end
            if (last) begin
                expected_dots.push_back(acc);
                acc = 32'd0;
            end
        endfunction

        function void check_result(input logic [31:0] r);
            logic [31:0] e;
            if (expected_dots.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, r);
                errors++;
            end else begin
                e = expected_dots.pop_front();
                if (e !== r) begin
                    $display("%0t: dot_result mismatch, expected %h, actual %h", $time, e, r);
                    errors++;
                end
            end
        endfunction
    endclass

    dot_scoreboard sb;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_group(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || !idle_on) begin
            m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_group(input logic [71:0] d, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [15:0] pick_scale();
        if ($urandom_range(0, 9) < 8)
            return {1'($urandom), 5'($urandom_range(4, 24)), 10'($urandom)};
        return 16'($urandom);
    endfunction

    function automatic logic [71:0] pack_group(input logic [7:0] codes, input logic [31:0] acts,
                                               input logic [15:0] ws, input logic [15:0] as);
        return {as, ws, acts, codes};
    endfunction

    task automatic send_row(input int len, input logic [15:0] ws, input logic [15:0] as);
        for (int g = 0; g < len; g++) begin
            send_group(pack_group(8'($urandom), $urandom, ws, as), g == len - 1);
        end
    endtask

    initial begin
        int len;
        sb = new();
        cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        idle_on = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_group(pack_group(8'hFF, {4{8'h7F}}, 16'h3C00, 16'h3C00), 1'b1);
        send_group(pack_group(8'h00, {4{8'h80}}, 16'h7BFF, 16'h7BFF), 1'b1);
        send_group(pack_group(8'hE4, 32'h807F_0180, 16'h0001, 16'h0001), 1'b1);
        send_group(pack_group(8'h55, $urandom, 16'h3C00, 16'h3C00), 1'b1);
        send_group(pack_group(8'hAA, 32'h0102_0304, 16'h7C00, 16'hBC00), 1'b1);
        send_group(pack_group(8'hAA, 32'h0102_0304, 16'h7C00, 16'h0000), 1'b1);
        send_group(pack_group(8'hFF, 32'h0102_0304, 16'h7E01, 16'hFD55), 1'b1);
        send_group(pack_group(8'hFF, 32'hFFFF_FFFF, 16'h8000, 16'h83FF), 1'b1);
        send_row(9, 16'h3555, 16'h2C00);
        send_row(8, 16'hFC00, 16'h3C00);
        for (int n = 0; n < 1650;) begin
            if (n > 1400) idle_on = 1'b0;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 32);
            for (int g = 0; g < len; g++) begin
                send_group(pack_group(8'($urandom), $urandom, pick_scale(), pick_scale()),
                           g == len - 1);
            end
            n += len;
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        while (sb.expected_dots.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> q2_q8_block_scaled_dot_core.f
+incdir+design
design/qdc_pkg.sv
design/qdc_front.sv
design/qdc_fifo.sv
design/qdc_back.sv
design/q2_q8_block_scaled_dot_core.sv
design/qdc_checker.sv
verif/testbench.sv
